>>> rtl/cfsd_pkg.sv
// shared types, constants and arithmetic helpers for the cloth spring-damper force unit
package cfsd_pkg;

  localparam int DATA_W      = 32;
  localparam int OUT_W       = 48;
  localparam int REST_W      = 31;
  localparam int CFG_IDX_W   = 8;
  localparam int SQ_W        = 64;
  localparam int ROOT_W      = 32;
  localparam int REM_W       = 36;
  localparam int ROOT_STEPS  = 32;
  localparam int STEP_W      = $clog2(ROOT_STEPS);
  localparam int K_W         = 15;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // spring constants per class (damping is applied by shift-add in the back end)
  localparam logic signed [K_W-1:0] K_STIFF = 15'sd7000;
  localparam logic signed [K_W-1:0] K_FLEX  = 15'sd200;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REST   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIND_X = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIND_Y = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIND_Z = 8'd3;

  typedef enum logic [1:0] {
    CLASS_ADJ  = 2'd0,
    CLASS_DIAG = 2'd1,
    CLASS_FLEX = 2'd2
  } spring_class_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_MUL,
    SEQ_ROOT
  } seq_state_t;

  typedef struct packed {
    spring_class_t            cls;
    logic                     fixed;
    logic                     degen;
    logic [2:0][DATA_W-1:0]   dp;
    logic [2:0][DATA_W-1:0]   dv;
  } spring_item_t;

  typedef struct packed {
    logic [REST_W-1:0]        rest_len;
    logic [ROOT_W-1:0]        rest_diag;
    logic [2:0][DATA_W-1:0]   wind;
  } cfg_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_acc_t;

  // one digit of the restoring square root: two radicand bits in, one root bit out
  function automatic sqrt_acc_t sqrt_step(input logic [REM_W-1:0] rem,
                                          input logic [ROOT_W-1:0] root,
                                          input logic [1:0] pair);
    sqrt_acc_t        res;
    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    acc   = {rem[REM_W-3:0], pair};
    trial = {{(REM_W-ROOT_W-2){1'b0}}, root, 2'b01};
    if (acc >= trial) begin
      res.rem  = acc - trial;
      res.root = {root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = acc;
      res.root = {root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [OUT_W-1:0] sat48(input logic [OUT_W:0] v);
    if (v[OUT_W] != v[OUT_W-1]) begin
      return v[OUT_W] ? OUT_MIN : OUT_MAX;
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

>>> rtl/cfsd_queue.sv
// short item queue between the front and back ends
module cfsd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  cfsd_pkg::spring_item_t push_item,
  output logic                  full,
  output logic                  q_valid,
  output cfsd_pkg::spring_item_t q_item
);
  import cfsd_pkg::*;

  spring_item_t mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign pop  = (count != '0);
  assign full = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q_item <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      q_valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count   <= count + QCNT_W'(push) - QCNT_W'(pop);
      q_valid <= pop;
    end
  end

endmodule

>>> rtl/cfsd_front.sv
// front end: config registers, diagonal rest length root, item accept and classification
module cfsd_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       mode,
  input  logic signed [cfsd_pkg::DATA_W-1:0] pos_diff_x,
  input  logic signed [cfsd_pkg::DATA_W-1:0] pos_diff_y,
  input  logic signed [cfsd_pkg::DATA_W-1:0] pos_diff_z,
  input  logic signed [cfsd_pkg::DATA_W-1:0] vel_diff_x,
  input  logic signed [cfsd_pkg::DATA_W-1:0] vel_diff_y,
  input  logic signed [cfsd_pkg::DATA_W-1:0] vel_diff_z,
  input  logic                             knot_fixed,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cfsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfsd_pkg::DATA_W-1:0]      cfg_data,
  input  logic                             q_full,
  output logic                             push,
  output cfsd_pkg::spring_item_t           push_item,
  output cfsd_pkg::cfg_t                   cfg
);
  import cfsd_pkg::*;

  localparam logic [REST_W-1:0] REST_RESET = REST_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(ROOT_STEPS - 1);

  seq_state_t        state;
  seq_state_t        state_next;
  logic [REST_W-1:0] rest_len;
  logic [ROOT_W-1:0] rest_diag;
  logic [DATA_W-1:0] wind_x;
  logic [DATA_W-1:0] wind_y;
  logic [DATA_W-1:0] wind_z;
  logic [SQ_W-1:0]   rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [STEP_W-1:0] step;
  logic [SQ_W-1:0]   len_sq;
  sqrt_acc_t         acc;
  logic              cfg_we;
  logic              seq_busy;
  spring_class_t     cls;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign len_sq    = SQ_W'(rest_len) * SQ_W'(rest_len);
  assign acc       = sqrt_step(rem, root, rad[SQ_W-1 -: 2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= SEQ_MUL;
      rest_len <= REST_RESET;
      wind_x   <= '0;
      wind_y   <= '0;
      wind_z   <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_REST:   rest_len <= cfg_data[REST_W-1:0];
          REG_WIND_X: wind_x   <= cfg_data;
          REG_WIND_Y: wind_y   <= cfg_data;
          REG_WIND_Z: wind_z   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // root of 2*L*L, one digit per cycle
  always_ff @(posedge clk) begin
    case (state)
      SEQ_MUL: begin
        rad  <= {len_sq[SQ_W-2:0], 1'b0};
        rem  <= '0;
        root <= '0;
        step <= '0;
      end
      SEQ_ROOT: begin
        rad  <= rad << 2;
        rem  <= acc.rem;
        root <= acc.root;
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          rest_diag <= acc.root;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: state_next = SEQ_IDLE;
      SEQ_MUL:  state_next = SEQ_ROOT;
      SEQ_ROOT: begin
        if (step == LAST_STEP) begin
          state_next = SEQ_IDLE;
        end
      end
      default:  state_next = SEQ_IDLE;
    endcase
    // a new base length restarts the root
    if (cfg_we && (cfg_index == REG_REST)) begin
      state_next = SEQ_MUL;
    end
  end

  always_comb begin
    seq_busy = (state != SEQ_IDLE);
    busy     = seq_busy | q_full;
    push     = start & ~busy;
  end

  always_comb begin
    case (spring_class_t'(mode))
      CLASS_ADJ:  cls = CLASS_ADJ;
      CLASS_DIAG: cls = CLASS_DIAG;
      default:    cls = CLASS_FLEX;
    endcase
  end

  always_comb begin
    push_item.cls   = cls;
    push_item.fixed = knot_fixed;
    push_item.degen = (pos_diff_x == '0) && (pos_diff_y == '0) && (pos_diff_z == '0);
    push_item.dp[0] = pos_diff_x;
    push_item.dp[1] = pos_diff_y;
    push_item.dp[2] = pos_diff_z;
    push_item.dv[0] = vel_diff_x;
    push_item.dv[1] = vel_diff_y;
    push_item.dv[2] = vel_diff_z;
    cfg.rest_len    = rest_len;
    cfg.rest_diag   = rest_diag;
    cfg.wind[0]     = wind_x;
    cfg.wind[1]     = wind_y;
    cfg.wind[2]     = wind_z;
  end

endmodule

>>> rtl/cfsd_back.sv
// back end: force pipeline, square root, divider, multiply and saturate
module cfsd_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  input  cfsd_pkg::spring_item_t                q_item,
  input  cfsd_pkg::cfg_t                        cfg,
  output logic                                  done,
  output logic [2:0][cfsd_pkg::OUT_W-1:0]       self_force,
  output logic [2:0][cfsd_pkg::OUT_W-1:0]       other_force,
  output logic                                  degenerate
);
  import cfsd_pkg::*;

  localparam int HAT_W      = FRAC_BITS + 1;
  localparam int DIV_STAGES = HAT_W;
  localparam int PP_W       = DATA_W + HAT_W;
  localparam int FULL_W     = 2 * DATA_W + HAT_W;
  localparam int SHR_W      = FULL_W - FRAC_BITS;
  localparam int DIFF_W     = ROOT_W + 1;
  localparam int KT_W       = DIFF_W + K_W;
  localparam logic [SHR_W-1:0] POS_LIM = SHR_W'(OUT_MAX);
  localparam logic [SHR_W-1:0] NEG_LIM = SHR_W'(OUT_MAX) + 1'b1;

  typedef struct packed {
    spring_class_t          cls;
    logic                   fixed;
    logic                   degen;
    logic [2:0][DATA_W-1:0] dp;
    logic [SQ_W-1:0]        bdot;
  } root_carry_t;

  typedef struct packed {
    spring_class_t     cls;
    logic              fixed;
    logic              degen;
    logic [2:0]        dp_neg;
    logic [SQ_W-1:0]   s;
    logic [ROOT_W-1:0] len;
  } div_carry_t;

  typedef struct packed {
    spring_class_t cls;
    logic          fixed;
    logic          degen;
  } tail_carry_t;

  // ---------------- stage a: squares and velocity products
  logic                   a_valid;
  spring_item_t           a_item;
  logic [SQ_W-1:0]        a_sq [3];
  logic signed [SQ_W-1:0] a_prod [3];
  logic [DATA_W-1:0]      in_mag [3];
  logic signed [SQ_W-1:0] in_dp [3];
  logic signed [SQ_W-1:0] in_dv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_mag[i] = mag32(q_item.dp[i]);
      in_dp[i]  = SQ_W'($signed(q_item.dp[i]));
      in_dv[i]  = SQ_W'($signed(q_item.dv[i]));
    end
  end

  always_ff @(posedge clk) begin
    a_item <= q_item;
    for (int i = 0; i < 3; i++) begin
      a_sq[i]   <= SQ_W'(in_mag[i]) * SQ_W'(in_mag[i]);
      a_prod[i] <= in_dp[i] * in_dv[i];
    end
  end

  // ---------------- stage b: length squared and dot product
  logic                   b_valid;
  spring_item_t           b_item;
  logic [SQ_W-1:0]        b_sum;
  logic signed [SQ_W-1:0] b_dot;

  always_ff @(posedge clk) begin
    b_item <= a_item;
    b_sum  <= a_sq[0] + a_sq[1] + a_sq[2];
    b_dot  <= (a_prod[0] >>> FRAC_BITS) + (a_prod[1] >>> FRAC_BITS)
            + (a_prod[2] >>> FRAC_BITS);
  end

  // ---------------- stage c: damping term (80 = 64 + 16, 30 = 32 - 2)
  logic            c_valid;
  root_carry_t     c_carry;
  logic [SQ_W-1:0] c_rad;

  always_ff @(posedge clk) begin
    c_rad         <= b_sum;
    c_carry.cls   <= b_item.cls;
    c_carry.fixed <= b_item.fixed;
    c_carry.degen <= b_item.degen;
    c_carry.dp    <= b_item.dp;
    if (b_item.cls == CLASS_FLEX) begin
      c_carry.bdot <= (b_dot <<< 5) - (b_dot <<< 1);
    end else begin
      c_carry.bdot <= (b_dot <<< 6) + (b_dot <<< 4);
    end
  end

  // ---------------- square root pipeline, one root bit per stage
  logic              sr_valid [ROOT_STEPS];
  logic [SQ_W-1:0]   sr_rad   [ROOT_STEPS];
  logic [REM_W-1:0]  sr_rem   [ROOT_STEPS];
  logic [ROOT_W-1:0] sr_root  [ROOT_STEPS];
  root_carry_t       sr_carry [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    logic              v_in;
    logic [SQ_W-1:0]   rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    root_carry_t       c_in;
    sqrt_acc_t         acc;

    if (k == 0) begin : g_first
      always_comb begin
        v_in    = c_valid;
        rad_in  = c_rad;
        rem_in  = '0;
        root_in = '0;
        c_in    = c_carry;
      end
    end else begin : g_next
      always_comb begin
        v_in    = sr_valid[k-1];
        rad_in  = sr_rad[k-1];
        rem_in  = sr_rem[k-1];
        root_in = sr_root[k-1];
        c_in    = sr_carry[k-1];
      end
    end

    assign acc = sqrt_step(rem_in, root_in, rad_in[SQ_W-1 -: 2]);

    always_ff @(posedge clk) begin
      if (rst) begin
        sr_valid[k] <= 1'b0;
      end else begin
        sr_valid[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      sr_rad[k]   <= rad_in << 2;
      sr_rem[k]   <= acc.rem;
      sr_root[k]  <= acc.root;
      sr_carry[k] <= c_in;
    end
  end

  // ---------------- spring scalar s = -k*(len - rest) - b*dot
  logic                     d1_valid;
  root_carry_t              d1_carry;
  logic [ROOT_W-1:0]        d1_len;
  logic signed [DIFF_W-1:0] d1_diff;
  logic [ROOT_W-1:0]        rest_sel;

  always_comb begin
    case (sr_carry[ROOT_STEPS-1].cls)
      CLASS_ADJ:  rest_sel = {1'b0, cfg.rest_len};
      CLASS_DIAG: rest_sel = cfg.rest_diag;
      default:    rest_sel = {cfg.rest_len, 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    d1_carry <= sr_carry[ROOT_STEPS-1];
    d1_len   <= sr_root[ROOT_STEPS-1];
    d1_diff  <= $signed({1'b0, sr_root[ROOT_STEPS-1]}) - $signed({1'b0, rest_sel});
  end

  logic                   d2_valid;
  root_carry_t            d2_carry;
  logic [ROOT_W-1:0]      d2_len;
  logic signed [KT_W-1:0] d2_kterm;
  logic signed [K_W-1:0]  k_sel;

  assign k_sel = (d1_carry.cls == CLASS_FLEX) ? K_FLEX : K_STIFF;

  always_ff @(posedge clk) begin
    d2_carry <= d1_carry;
    d2_len   <= d1_len;
    d2_kterm <= KT_W'(d1_diff) * KT_W'(k_sel);
  end

  logic              d3_valid;
  div_carry_t        d3_carry;
  logic [DATA_W-1:0] d3_mag [3];

  always_ff @(posedge clk) begin
    d3_carry.cls   <= d2_carry.cls;
    d3_carry.fixed <= d2_carry.fixed;
    d3_carry.degen <= d2_carry.degen;
    d3_carry.len   <= d2_len;
    d3_carry.s     <= -SQ_W'(d2_kterm) - $signed(d2_carry.bdot);
    for (int i = 0; i < 3; i++) begin
      d3_carry.dp_neg[i] <= d2_carry.dp[i][DATA_W-1];
      d3_mag[i]          <= mag32(d2_carry.dp[i]);
    end
  end

  // ---------------- unit direction dp * 2^F / len, one quotient bit per stage
  logic              dvs_valid [DIV_STAGES];
  div_carry_t        dvs_carry [DIV_STAGES];
  logic [ROOT_W:0]   dvs_rem   [DIV_STAGES][3];
  logic [HAT_W-1:0]  dvs_q     [DIV_STAGES][3];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic             v_in;
    div_carry_t       c_in;
    logic [ROOT_W:0]  r_in  [3];
    logic [HAT_W-1:0] q_in  [3];
    logic [ROOT_W:0]  r_out [3];
    logic [HAT_W-1:0] q_out [3];

    if (j == 0) begin : g_first
      always_comb begin
        v_in = d3_valid;
        c_in = d3_carry;
        for (int i = 0; i < 3; i++) begin
          r_in[i] = {1'b0, d3_mag[i]};
          q_in[i] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        v_in = dvs_valid[j-1];
        c_in = dvs_carry[j-1];
        for (int i = 0; i < 3; i++) begin
          r_in[i] = {dvs_rem[j-1][i][ROOT_W-1:0], 1'b0};
          q_in[i] = dvs_q[j-1][i];
        end
      end
    end

    always_comb begin
      logic [ROOT_W:0] divisor;
      logic            ge;
      divisor = {1'b0, c_in.len};
      for (int i = 0; i < 3; i++) begin
        ge       = (r_in[i] >= divisor);
        r_out[i] = ge ? (r_in[i] - divisor) : r_in[i];
        q_out[i] = {q_in[i][HAT_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvs_valid[j] <= 1'b0;
      end else begin
        dvs_valid[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      dvs_carry[j] <= c_in;
      for (int i = 0; i < 3; i++) begin
        dvs_rem[j][i] <= r_out[i];
        dvs_q[j][i]   <= q_out[i];
      end
    end
  end

  // ---------------- f = s * hat / 2^F, from partial products of the two 32-bit halves of |s|
  logic            m1_valid;
  tail_carry_t     m1_carry;
  logic            m1_neg [3];
  logic [PP_W-1:0] m1_p1 [3];
  logic [PP_W-1:0] m1_p0 [3];
  logic [SQ_W-1:0] s_mag;
  div_carry_t      dl;

  assign dl    = dvs_carry[DIV_STAGES-1];
  assign s_mag = dl.s[SQ_W-1] ? (~dl.s + 1'b1) : dl.s;

  always_ff @(posedge clk) begin
    m1_carry.cls   <= dl.cls;
    m1_carry.fixed <= dl.fixed;
    m1_carry.degen <= dl.degen;
    for (int i = 0; i < 3; i++) begin
      m1_neg[i] <= dl.s[SQ_W-1] ^ dl.dp_neg[i];
      m1_p1[i]  <= PP_W'(s_mag[SQ_W-1:DATA_W]) * PP_W'(dvs_q[DIV_STAGES-1][i]);
      m1_p0[i]  <= PP_W'(s_mag[DATA_W-1:0]) * PP_W'(dvs_q[DIV_STAGES-1][i]);
    end
  end

  logic             m2_valid;
  tail_carry_t      m2_carry;
  logic [OUT_W-1:0] m2_f [3];

  always_ff @(posedge clk) begin
    logic [FULL_W-1:0] full;
    logic [SHR_W-1:0]  shr;
    logic [SHR_W-1:0]  lim;
    logic [OUT_W-1:0]  fmag;
    m2_carry <= m1_carry;
    for (int i = 0; i < 3; i++) begin
      full = {m1_p1[i], {DATA_W{1'b0}}} + FULL_W'(m1_p0[i]);
      shr  = full[FULL_W-1:FRAC_BITS];
      lim  = m1_neg[i] ? NEG_LIM : POS_LIM;
      fmag = shr[OUT_W-1:0];
      if (shr > lim) begin
        m2_f[i] <= m1_neg[i] ? OUT_MIN : OUT_MAX;
      end else begin
        m2_f[i] <= m1_neg[i] ? (~fmag + 1'b1) : fmag;
      end
    end
  end

  // ---------------- wind, saturation, output register
  always_ff @(posedge clk) begin
    logic [OUT_W:0] f_ext;
    logic [OUT_W:0] w_ext;
    logic [OUT_W:0] w_other;
    degenerate <= m2_carry.degen;
    for (int i = 0; i < 3; i++) begin
      f_ext   = {m2_f[i][OUT_W-1], m2_f[i]};
      w_ext   = (OUT_W+1)'($signed(cfg.wind[i]));
      w_other = (m2_carry.cls == CLASS_ADJ) ? w_ext : '0;
      if (m2_carry.fixed || m2_carry.degen) begin
        self_force[i]  <= '0;
        other_force[i] <= '0;
      end else begin
        self_force[i]  <= sat48(f_ext + w_ext);
        other_force[i] <= sat48(w_other - f_ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      c_valid  <= 1'b0;
      d1_valid <= 1'b0;
      d2_valid <= 1'b0;
      d3_valid <= 1'b0;
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      a_valid  <= q_valid;
      b_valid  <= a_valid;
      c_valid  <= b_valid;
      d1_valid <= sr_valid[ROOT_STEPS-1];
      d2_valid <= d1_valid;
      d3_valid <= d2_valid;
      m1_valid <= dvs_valid[DIV_STAGES-1];
      m2_valid <= m1_valid;
      done     <= m2_valid;
    end
  end

endmodule

>>> rtl/cloth_spring_damper_force_top.sv
// top level of the cloth spring-damper force unit
// throughput: one spring per cycle while busy is low, set by the 32-stage square root and the
// FRAC_BITS+1 stage divider, both fully pipelined; the receiver cannot stall
// reset: synchronous, resets the control state, clears the wind registers and sets the base
// rest length to 1 << FRAC_BITS, then the diagonal rest length root runs with busy high
// (also after each write of the base rest length)
module cloth_spring_damper_force_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // item transfer
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         mode,
  input  logic signed [cfsd_pkg::DATA_W-1:0] pos_diff_x,
  input  logic signed [cfsd_pkg::DATA_W-1:0] pos_diff_y,
  input  logic signed [cfsd_pkg::DATA_W-1:0] pos_diff_z,
  input  logic signed [cfsd_pkg::DATA_W-1:0] vel_diff_x,
  input  logic signed [cfsd_pkg::DATA_W-1:0] vel_diff_y,
  input  logic signed [cfsd_pkg::DATA_W-1:0] vel_diff_z,
  input  logic                               knot_fixed,
  // config write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cfsd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cfsd_pkg::DATA_W-1:0]        cfg_data,
  // result strobe
  output logic                               done,
  output logic signed [cfsd_pkg::OUT_W-1:0]  self_force_x,
  output logic signed [cfsd_pkg::OUT_W-1:0]  self_force_y,
  output logic signed [cfsd_pkg::OUT_W-1:0]  self_force_z,
  output logic signed [cfsd_pkg::OUT_W-1:0]  other_force_x,
  output logic signed [cfsd_pkg::OUT_W-1:0]  other_force_y,
  output logic signed [cfsd_pkg::OUT_W-1:0]  other_force_z,
  output logic                               degenerate
);
  import cfsd_pkg::*;

  // start transfer to done strobe, counted in clock edges
  localparam int LATENCY = 44 + FRAC_BITS;

  logic                   q_full;
  logic                   push;
  spring_item_t           push_item;
  cfg_t                   cfg;
  logic                   q_valid;
  spring_item_t           q_item;
  logic [2:0][OUT_W-1:0]  self_force;
  logic [2:0][OUT_W-1:0]  other_force;

  // front end: registers, classification, diagonal rest root
  cfsd_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .pos_diff_x (pos_diff_x),
    .pos_diff_y (pos_diff_y),
    .pos_diff_z (pos_diff_z),
    .vel_diff_x (vel_diff_x),
    .vel_diff_y (vel_diff_y),
    .vel_diff_z (vel_diff_z),
    .knot_fixed (knot_fixed),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item),
    .cfg        (cfg)
  );

  // decoupling queue; the back end drains it every cycle
  cfsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // back end: the force pipeline itself
  cfsd_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .cfg         (cfg),
    .done        (done),
    .self_force  (self_force),
    .other_force (other_force),
    .degenerate  (degenerate)
  );

  assign self_force_x  = $signed(self_force[0]);
  assign self_force_y  = $signed(self_force[1]);
  assign self_force_z  = $signed(self_force[2]);
  assign other_force_x = $signed(other_force[0]);
  assign other_force_y = $signed(other_force[1]);
  assign other_force_z = $signed(other_force[2]);

  // every accepted spring comes out after a fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result strobe missing after item transfer");

  // a zero-length spring never reports a force
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (self_force_x == '0 && self_force_y == '0 &&
      self_force_z == '0 && other_force_x == '0 && other_force_y == '0 &&
      other_force_z == '0))
    else $error("nonzero force on degenerate spring");

  // new base length must hold off items until its diagonal root is ready
  a_rest_busy: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index == REG_REST) |=> busy)
    else $error("item accepted while diagonal rest root is stale");

endmodule

>>> sim/tb_cloth_spring_damper_force_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the cloth spring-damper force unit
module tb_cloth_spring_damper_force_top;
  import cfsd_pkg::*;

  localparam int              FRAC      = 16;
  localparam int              LATENCY   = 44 + FRAC;
  localparam int              CYC_LIMIT = 400000;
  localparam logic [1:0]      MODE_SPARE = 2'd3;     // unused class code, behaves as flex
  localparam logic [7:0]      REG_SPARE  = 8'd7;     // write to nowhere, must be ignored
  localparam longint          F_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint          F_MIN = -F_MAX - 1;
  localparam int              N_PHASES = 6;
  localparam int              PER_PHASE = 175;

  typedef struct {
    logic [1:0]  md;
    logic [31:0] dp [3];
    logic [31:0] dv [3];
    logic        fx;
    bit          typed;      // expected result written in the table row
    bit          zero_deg;   // typed expectation: zero forces with this degenerate flag
  } spring_row_t;

  typedef struct {
    logic [47:0] self_f [3];
    logic [47:0] other_f [3];
    logic        degen;
  } spring_forces_t;

  logic        clk, rst;
  logic        start, busy;
  logic [1:0]  mode;
  logic signed [31:0] pos_diff_x, pos_diff_y, pos_diff_z;
  logic signed [31:0] vel_diff_x, vel_diff_y, vel_diff_z;
  logic        knot_fixed;
  logic        cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;
  logic        done;
  logic signed [47:0] self_force_x, self_force_y, self_force_z;
  logic signed [47:0] other_force_x, other_force_y, other_force_z;
  logic        degenerate;

  // shadow copy of the register file
  logic [30:0] rest_base;
  logic signed [31:0] wind [3];

  spring_row_t    cur_row;        // row being offered, read by the monitor at transfer
  spring_forces_t pending_forces[$];
  int unsigned    mismatches;
  int unsigned    cycles;
  bit             no_gaps;

  cloth_spring_damper_force_top #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .pos_diff_x(pos_diff_x), .pos_diff_y(pos_diff_y), .pos_diff_z(pos_diff_z),
    .vel_diff_x(vel_diff_x), .vel_diff_y(vel_diff_y), .vel_diff_z(vel_diff_z),
    .knot_fixed(knot_fixed), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .self_force_x(self_force_x), .self_force_y(self_force_y), .self_force_z(self_force_z),
    .other_force_x(other_force_x), .other_force_y(other_force_y),
    .other_force_z(other_force_z), .degenerate(degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // bitwise restoring integer square root, floor result
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp48(longint v);
    if (v > F_MAX) return F_MAX;
    if (v < F_MIN) return F_MIN;
    return v;
  endfunction

  // s*h scaled down by the fraction bits, truncated toward zero, clamped to 48 bits
  function automatic longint scale_force(longint s, longint h);
    bit neg;
    logic [127:0] prod;
    longint unsigned ms, mh;
    neg  = (s < 0) != (h < 0);
    ms   = (s < 0) ? -s : s;
    mh   = (h < 0) ? -h : h;
    prod = (128'(ms) * 128'(mh)) >> FRAC;
    if (prod > 128'(F_MAX) + (neg ? 1 : 0)) return neg ? F_MIN : F_MAX;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // force pair on knot and neighbor for one spring under the current registers
  function automatic spring_forces_t spring_force(spring_row_t r);
    spring_forces_t res;
    longint dp [3];
    longint dv [3];
    longint unsigned sq_sum, len, rest, m;
    longint dot, s, k, b, hat, f;
    for (int i = 0; i < 3; i++) begin
      dp[i] = longint'(signed'(r.dp[i]));
      dv[i] = longint'(signed'(r.dv[i]));
    end
    sq_sum = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      m = (dp[i] < 0) ? -dp[i] : dp[i];
      sq_sum += m * m;
      dot    += (dv[i] * dp[i]) >>> FRAC;
      res.self_f[i]  = '0;
      res.other_f[i] = '0;
    end
    res.degen = (sq_sum == 0);
    if (r.fx || res.degen) return res;
    len = int_sqrt(sq_sum);
    case (r.md)
      CLASS_ADJ: begin
        rest = rest_base; k = 7000; b = 80;
      end
      CLASS_DIAG: begin
        rest = int_sqrt(64'd2 * rest_base * rest_base); k = 7000; b = 80;
      end
      default: begin
        rest = 64'd2 * rest_base; k = 200; b = 30;
      end
    endcase
    s = -k * (longint'(len) - longint'(rest)) - b * dot;
    for (int i = 0; i < 3; i++) begin
      hat = (dp[i] * 64'sd65536) / longint'(len);
      f   = scale_force(s, hat);
      res.self_f[i]  = 48'(clamp48(f + wind[i]));
      res.other_f[i] = 48'(clamp48(-f + ((r.md == CLASS_ADJ) ? longint'(wind[i]) : 0)));
    end
    return res;
  endfunction

  // monitor: record an expectation per item transfer, check each done strobe
  always @(posedge clk) begin
    spring_forces_t want;
    bit bad;
    if (!rst) begin
      cycles <= cycles + 1;
      if (start && !busy) begin
        if (cur_row.typed) begin
          for (int i = 0; i < 3; i++) begin
            want.self_f[i]  = '0;
            want.other_f[i] = '0;
          end
          want.degen = cur_row.zero_deg;
          pending_forces.push_back(want);
        end else begin
          pending_forces.push_back(spring_force(cur_row));
        end
      end
      if (done) begin
        if (pending_forces.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
        end else begin
          want = pending_forces.pop_front();
          bad = (self_force_x !== want.self_f[0]) || (self_force_y !== want.self_f[1]) ||
                (self_force_z !== want.self_f[2]) || (other_force_x !== want.other_f[0]) ||
                (other_force_y !== want.other_f[1]) || (other_force_z !== want.other_f[2]) ||
                (degenerate !== want.degen);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch cycle %0d self exp %h %h %h got %h %h %h", cycles,
                       want.self_f[0], want.self_f[1], want.self_f[2],
                       self_force_x, self_force_y, self_force_z);
              $display("  other exp %h %h %h got %h %h %h  degen exp %b got %b",
                       want.other_f[0], want.other_f[1], want.other_f[2],
                       other_force_x, other_force_y, other_force_z, want.degen, degenerate);
            end
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYC_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // hold off until the pipeline has drained so register writes land on an idle block
  task automatic drain();
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // one register transfer, shadow updated at the transfer edge
  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_valid && cfg_ready) break;
    end
    case (idx)
      REG_REST:   rest_base = val[30:0];
      REG_WIND_X: wind[0] = val;
      REG_WIND_Y: wind[1] = val;
      REG_WIND_Z: wind[2] = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [30:0] rl, logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
    drain();
    write_reg(REG_REST, {1'b0, rl});
    write_reg(REG_WIND_X, wx);
    write_reg(REG_WIND_Y, wy);
    write_reg(REG_WIND_Z, wz);
    write_reg(REG_SPARE, $urandom);
    cfg_valid <= 1'b0;
  endtask

  // offer one spring and wait for its transfer; random gaps unless in the quiet stretch
  task automatic send_spring(spring_row_t r);
    if (!no_gaps && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start      <= 1'b1;
    mode       <= r.md;
    pos_diff_x <= r.dp[0];
    pos_diff_y <= r.dp[1];
    pos_diff_z <= r.dp[2];
    vel_diff_x <= r.dv[0];
    vel_diff_y <= r.dv[1];
    vel_diff_z <= r.dv[2];
    knot_fixed <= r.fx;
    cur_row    <= r;
    forever begin
      @(posedge clk);
      if (start && !busy) break;
    end
  endtask

  // mostly cloth-scale values near the rest length, some full range and extremes
  function automatic logic [31:0] rand_axis();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8)  return '0;
    if (pick < 60) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    if (pick < 68) return (pick[0]) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic spring_row_t rand_row();
    spring_row_t r;
    r.md = 2'($urandom_range(3));
    for (int i = 0; i < 3; i++) begin
      r.dp[i] = rand_axis();
      r.dv[i] = rand_axis();
    end
    if ($urandom_range(99) < 6) r.dp = '{0, 0, 0};
    r.fx = ($urandom_range(99) < 10);
    r.typed = 1'b0;
    r.zero_deg = 1'b0;
    return r;
  endfunction

  // directed rows: class, dp xyz, dv xyz, static, typed, degenerate
  spring_row_t directed [] = '{
    '{CLASS_ADJ,  '{0, 0, 0}, '{32'h0001_0000, 0, 0}, 1'b0, 1'b1, 1'b1},
    '{CLASS_DIAG, '{0, 0, 0}, '{0, 0, 0}, 1'b1, 1'b1, 1'b1},
    '{CLASS_FLEX, '{32'h0002_0000, 0, 0}, '{0, 0, 0}, 1'b1, 1'b1, 1'b0},
    '{MODE_SPARE, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b1, 1'b1, 1'b0},
    '{CLASS_ADJ,  '{32'h0001_0000, 0, 0}, '{0, 0, 0}, 1'b0, 1'b0, 1'b0},
    '{CLASS_ADJ,  '{32'h0002_0000, 0, 0}, '{0, 0, 0}, 1'b0, 1'b0, 1'b0},
    '{CLASS_ADJ,  '{0, 32'hFFFF_8000, 0}, '{0, 32'h0000_4000, 0}, 1'b0, 1'b0, 1'b0},
    '{CLASS_DIAG, '{32'h0001_0000, 32'h0001_0000, 0}, '{0, 0, 0}, 1'b0, 1'b0, 1'b0},
    '{CLASS_DIAG, '{0, 0, 32'h0003_0000}, '{0, 0, 32'hFFFE_0000}, 1'b0, 1'b0, 1'b0},
    '{CLASS_FLEX, '{32'h0002_0000, 0, 0}, '{32'h0001_0000, 0, 0}, 1'b0, 1'b0, 1'b0},
    '{CLASS_FLEX, '{0, 32'h0000_8000, 32'hFFFF_8000}, '{0, 0, 0}, 1'b0, 1'b0, 1'b0},
    '{MODE_SPARE, '{32'h0002_0000, 0, 0}, '{32'h0001_0000, 0, 0}, 1'b0, 1'b0, 1'b0},
    '{CLASS_ADJ,  '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, 1'b0, 1'b0},
    '{CLASS_ADJ,  '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, 1'b0, 1'b0},
    '{CLASS_DIAG, '{32'h8000_0000, 0, 32'h7FFF_FFFF},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0, 1'b0, 1'b0},
    '{CLASS_FLEX, '{32'h0000_0001, 0, 0}, '{32'h7FFF_FFFF, 0, 0}, 1'b0, 1'b0, 1'b0},
    '{CLASS_ADJ,  '{0, 0, 32'hFFFF_FFFF}, '{0, 0, 32'h8000_0000}, 1'b0, 1'b0, 1'b0},
    '{CLASS_DIAG, '{32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678},
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'hEDCB_A988}, 1'b0, 1'b0, 1'b0}
  };

  initial begin
    rst = 1'b1;
    start = 1'b0; mode = CLASS_ADJ; knot_fixed = 1'b0;
    pos_diff_x = '0; pos_diff_y = '0; pos_diff_z = '0;
    vel_diff_x = '0; vel_diff_y = '0; vel_diff_z = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    cur_row = directed[0];
    mismatches = 0; cycles = 0; no_gaps = 1'b0;
    // register state after reset
    rest_base = 31'h0001_0000;
    wind = '{0, 0, 0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed rows at reset values, then untyped rows with wind to show the wind split
    foreach (directed[i]) send_spring(directed[i]);
    start <= 1'b0;
    set_regs(31'h0001_8000, 32'h0000_4000, 32'hFFFF_C000, 32'h0001_0000);
    foreach (directed[i]) if (!directed[i].typed) send_spring(directed[i]);
    start <= 1'b0;

    // random phases, each with its own register setting, extremes among them
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: set_regs(31'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        1: set_regs(31'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        2: set_regs(31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        default: set_regs(31'($urandom_range(0, 32'h0004_0000)), $urandom, $urandom,
                          $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
      endcase
      for (int n = 0; n < PER_PHASE; n++) begin
        no_gaps = (p == 3);   // one phase with back-to-back transfers only
        send_spring(rand_row());
      end
      start <= 1'b0;
    end

    // drain and settle
    while (pending_forces.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
